[hw/rtl/psvs_pkg.sv]
// package: shared types, register indexes and constants for the pcm step volume scaler
package psvs_pkg;

	localparam int MAX_STEPS_DEF = 63;

	localparam int SAMPLE_W = 16;
	localparam int VOL_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = VOL_W;

	localparam logic [CFG_IDX_W-1:0] REG_VOLUME_STEPS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDE_SAMPLES = 2'd1;

	localparam logic signed [16:0] SAT_HI_WIDE   = 17'sd32767;
	localparam logic signed [16:0] SAT_LO_WIDE   = -17'sd32768;
	localparam logic signed [16:0] SAT_HI_NARROW = 17'sd127;
	localparam logic signed [16:0] SAT_LO_NARROW = -17'sd128;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       last_in;
	} psvs_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_out;
	} psvs_out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} psvs_cmd_t;

	typedef struct packed {
		logic cnt_zero;
	} psvs_stat_t;

endpackage

[hw/rtl/psvs_ctrl.sv]
// controller: sequences load, scaling steps and result capture for one request
module psvs_ctrl
	import psvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  psvs_stat_t stat,
	output psvs_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic state_q;
	logic state_d;
	logic done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.cnt_zero) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q == ST_RUN);
	assign done = done_q;

endmodule

[hw/rtl/psvs_dp.sv]
// datapath: config registers, step counter, shared 1.25 / 0.75 scale unit, result register
module psvs_dp
	import psvs_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  psvs_in_t              item,
	input  psvs_cmd_t             cmd,
	output psvs_stat_t            stat,
	output psvs_out_t             result
);

	localparam int CNT_W = (MAX_STEPS < 2) ? 1 : $clog2(MAX_STEPS + 1);
	localparam logic [8:0] MAX_C = 9'(MAX_STEPS);

	logic signed [VOL_W-1:0]    vol_q;
	logic                       wide_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic                       raise_q;
	logic                       wide_run_q;
	logic                       last_q;
	logic [CNT_W-1:0]           cnt_q;
	psvs_out_t                  result_q;

	logic signed [7:0]          vol_ext;
	logic [7:0]                 mag;
	logic [8:0]                 n_clamp;
	logic signed [SAMPLE_W-1:0] x_load;
	logic signed [18:0]         x19;
	logic signed [18:0]         prod;
	logic signed [18:0]         prod_b;
	logic signed [16:0]         quo;
	logic signed [16:0]         sat_hi;
	logic signed [16:0]         sat_lo;
	logic signed [SAMPLE_W-1:0] x_next;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= '0;
			wide_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_VOLUME_STEPS: vol_q  <= cfg_data;
				REG_WIDE_SAMPLES: wide_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// step count magnitude clamped to the bound, and the sample to load (low byte sign-extended when narrow)
	always_comb begin
		vol_ext = {vol_q[VOL_W-1], vol_q};
		mag     = vol_q[VOL_W-1] ? 8'(-vol_ext) : 8'(vol_ext);
		n_clamp = ({1'b0, mag} > MAX_C) ? MAX_C : {1'b0, mag};
		x_load  = wide_q ? item.sample_in
			: {{8{item.sample_in[7]}}, item.sample_in[7:0]};
	end

	// one scale step: trunc(5x/4) or trunc(3x/4), then saturate
	always_comb begin
		x19    = 19'(x_q);
		prod   = raise_q ? ((x19 <<< 2) + x19) : ((x19 <<< 1) + x19);
		prod_b = prod + (prod[18] ? 19'sd3 : 19'sd0);
		quo    = prod_b[18:2];
		sat_hi = wide_run_q ? SAT_HI_WIDE : SAT_HI_NARROW;
		sat_lo = wide_run_q ? SAT_LO_WIDE : SAT_LO_NARROW;
		if (quo > sat_hi) begin
			x_next = 16'(sat_hi);
		end else if (quo < sat_lo) begin
			x_next = 16'(sat_lo);
		end else begin
			x_next = 16'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CNT_W'(n_clamp);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q        <= x_load;
			raise_q    <= !vol_q[VOL_W-1] && (vol_q != '0);
			wide_run_q <= wide_q;
			last_q     <= item.last_in;
		end else if (cmd.step) begin
			x_q <= x_next;
		end
		if (cmd.finish) begin
			result_q.sample_out <= x_q;
			result_q.last_out   <= last_q;
		end
	end

	assign stat.cnt_zero = (cnt_q == '0);
	assign result        = result_q;

endmodule

[hw/rtl/pcm_step_volume_scaler_top.sv]
// top level: pcm step volume scaler, controller plus datapath
//
// channel   signals                      transfer
// request   start, busy, item            start high and busy low at a rising edge
// result    done, result                 done high for one cycle, always taken
// config    cfg_we, cfg_idx, cfg_data    cfg_we high at a rising edge
//
// a request runs n scale steps and then captures the result, n being |volume_steps|
// clamped to MAX_STEPS; one shared scale unit does one step per cycle
// busy is high from the cycle after acceptance until the cycle done shows
// a new request can be taken in the cycle done is high
// reset clears config registers to zero and returns the controller to idle
module pcm_step_volume_scaler_top
	import psvs_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  psvs_in_t              item,
	output logic                  done,
	output psvs_out_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	psvs_cmd_t  cmd;
	psvs_stat_t stat;
	logic       busy_i;

	psvs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy_i),
		.done   (done)
	);

	psvs_dp #(
		.MAX_STEPS (MAX_STEPS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	assign busy = busy_i;

endmodule

[hw/rtl/psvs_chk.sv]
// checker: port-level sequencing properties of the pcm step volume scaler, with bind
module psvs_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// accepted request makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) (start && !busy) |=> busy)
		else $error("request accepted but busy not raised");

	// a result is only shown once the block is free again
	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("done while busy");

	// busy drops exactly when the result shows
	assert property (@(posedge clk) disable iff (!arst_n) $fell(busy) |-> done)
		else $error("busy dropped without result");

	// each request passes through the run state before done, so results never come back to back
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("back to back done");

endmodule

bind pcm_step_volume_scaler_top psvs_chk u_psvs_chk (.*);
